// File: rtl/core/tilt_average_led_display_core_assert.svh
// Assertion macros for the tilt display core.
// Used by the top level; needs signals named clk and rst in scope.
`ifndef TILT_AVERAGE_LED_DISPLAY_CORE_ASSERT_SVH
`define TILT_AVERAGE_LED_DISPLAY_CORE_ASSERT_SVH
`ifndef SYNTH
`define TAD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TAD_ASSERT_NOW(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TAD_ASSERT(label, prop, msg)
`define TAD_ASSERT_NOW(label, prop, msg)
`endif
`endif

// File: rtl/core/tad_pkg.sv
// Shared types, constants and the LED pattern table for the tilt display core.
// No dependencies.
package tad_pkg;

  localparam int SMP_W     = 16;
  localparam int LED_W     = 8;
  localparam int LEVEL_W   = 5;
  localparam int VAL_W     = 9;
  localparam int AVG_SHIFT = 7;
  localparam logic [VAL_W-1:0] VALUE_OFFSET = 9'd32;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } line_ctl_t;

  typedef struct packed {
    logic adv;
    logic load;
    logic tick;
  } disp_ctl_t;

  function automatic logic [LED_W-1:0] code_to_leds(input logic [2:0] code);
    logic [LED_W-1:0] pat;
    case (code)
      3'd0:    pat = 8'd8;
      3'd1:    pat = 8'd4;
      3'd2:    pat = 8'd2;
      3'd3:    pat = 8'd1;
      3'd4:    pat = 8'd128;
      3'd5:    pat = 8'd64;
      3'd6:    pat = 8'd32;
      3'd7:    pat = 8'd16;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/core/tad_line.sv
// Circular sample delay line in a synchronous memory with a registered read.
// Depends on tad_pkg.
module tad_line #(
  parameter int WINDOW = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  tad_pkg::line_ctl_t                ctl,
  input  logic signed [tad_pkg::SMP_W-1:0]  wr_data,
  output logic signed [tad_pkg::SMP_W-1:0]  old_data
);
  import tad_pkg::*;

  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(WINDOW - 1);

  logic [SMP_W-1:0] mem [WINDOW];
  logic [IDX_W-1:0] slot;
  logic [IDX_W-1:0] rd_slot;
  logic             wrapped;
  logic             rd_ok;
  logic [SMP_W-1:0] rd_data;

  // Entries are written in slot order, so an entry holds real data exactly
  // when the slot pointer has gone once around the line.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= '0;
      wrapped <= 1'b0;
    end else if (ctl.rd_en) begin
      if (slot == LAST) begin
        slot    <= '0;
        wrapped <= 1'b1;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[slot];
      rd_slot <= slot;
      rd_ok   <= wrapped;
    end
    if (ctl.wr_en) begin
      mem[rd_slot] <= wr_data;
    end
  end

  assign old_data = rd_ok ? $signed(rd_data) : '0;

endmodule

// File: rtl/core/tad_disp.sv
// LED pattern and level registers, PWM counter and the output register.
// Depends on tad_pkg.
module tad_disp #(
  parameter int PWM_TOP = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  tad_pkg::disp_ctl_t               ctl,
  input  logic [tad_pkg::VAL_W-1:0]        value,
  output logic                             led_valid,
  output logic [tad_pkg::LED_W-1:0]        led_data
);
  import tad_pkg::*;

  localparam int PWM_W = $clog2(PWM_TOP + 2);
  localparam int CMP_W = (PWM_W > LEVEL_W) ? PWM_W : LEVEL_W;
  localparam logic [PWM_W-1:0] PWM_LAST = PWM_W'(PWM_TOP + 1);

  logic [LED_W-1:0]   pattern;
  logic [LEVEL_W-1:0] duty_level;
  logic [PWM_W-1:0]   pwm_count;
  logic [VAL_W-1:0]   shifted;
  logic               dim;

  assign shifted = value - VALUE_OFFSET;
  assign dim     = CMP_W'(pwm_count) < CMP_W'(duty_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern    <= '0;
      duty_level <= '0;
      pwm_count  <= '0;
      led_valid  <= 1'b0;
    end else if (ctl.adv) begin
      led_valid <= ctl.tick;
      if (ctl.load) begin
        pattern    <= code_to_leds(shifted[8:6]);
        duty_level <= shifted[5:1];
      end
      if (ctl.tick) begin
        pwm_count <= (pwm_count == PWM_LAST) ? '0 : pwm_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv && ctl.tick) begin
      led_data <= dim ? (pattern >> 1) : pattern;
    end
  end

endmodule

// File: rtl/core/tilt_average_led_display_core.sv
// Top level of the tilt display core: input stage, running sum, submodules.
// Depends on tad_pkg, tad_line, tad_disp and the assertion macro header.
//
//  channel   dir  payload                          transfer when
//  s_axis    in   tdata: sample; tuser: mode       s_axis_tvalid & s_axis_tready
//  m_axis    out  tdata: led_out                   m_axis_tvalid & m_axis_tready
//  cfg       in   cfg_wdata: use_filtered          cfg_wen
//
// One item per cycle unless stalled; ticks pass input stage and output register.
// The delay line memory is read when a sample is taken and written as the
// sample leaves the input stage, always at a different entry than the next read.
// Reset clears the line logically through a wrap flag, so no clearing pass.
// A full output register that is not taken stalls the whole pipe.
`include "tilt_average_led_display_core_assert.svh"
module tilt_average_led_display_core #(
  parameter int WINDOW  = 128,
  parameter int PWM_TOP = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic                        cfg_wdata,      // use_filtered
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tad_pkg::SMP_W-1:0]   s_axis_tdata,   // [15:0] sample
  input  logic                        s_axis_tuser,   // [0] mode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [tad_pkg::LED_W-1:0]   m_axis_tdata    // [7:0] led_out
);
  import tad_pkg::*;

  localparam int SUM_W = SMP_W + ((WINDOW > 1) ? $clog2(WINDOW) : 1);

  logic                    use_filtered;
  logic                    adv;
  logic                    s_accept;
  logic                    s1_valid;
  logic                    s1_mode;
  logic signed [SMP_W-1:0] s1_sample;
  logic signed [SMP_W-1:0] old_sample;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [SUM_W-1:0] window_sum_next;
  logic [VAL_W-1:0]        value;
  line_ctl_t               line_ctl;
  disp_ctl_t               disp_ctl;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_filtered <= 1'b0;
    end else if (cfg_wen) begin
      use_filtered <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_mode   <= s_axis_tuser;
      s1_sample <= $signed(s_axis_tdata);
    end
  end

  assign line_ctl.rd_en = s_accept && !s_axis_tuser;
  assign line_ctl.wr_en = adv && s1_valid && !s1_mode;

  tad_line #(
    .WINDOW (WINDOW)
  ) u_line (
    .clk      (clk),
    .rst      (rst),
    .ctl      (line_ctl),
    .wr_data  (s1_sample),
    .old_data (old_sample)
  );

  assign window_sum_next = window_sum + SUM_W'(s1_sample) - SUM_W'(old_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
    end else if (line_ctl.wr_en) begin
      window_sum <= window_sum_next;
    end
  end

  // Only the low nine bits of the selected value reach the pattern and level,
  // so the average needs just sum bits 15..7.
  assign value = use_filtered ? window_sum_next[AVG_SHIFT +: VAL_W]
                              : s1_sample[VAL_W-1:0];

  assign disp_ctl.adv  = adv;
  assign disp_ctl.load = s1_valid && !s1_mode;
  assign disp_ctl.tick = s1_valid && s1_mode;

  tad_disp #(
    .PWM_TOP (PWM_TOP)
  ) u_disp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (disp_ctl),
    .value     (value),
    .led_valid (m_axis_tvalid),
    .led_data  (m_axis_tdata)
  );

  `TAD_ASSERT(a_tick_gives_led, (adv && s1_valid && s1_mode) |=> m_axis_tvalid, "tick lost")
  `TAD_ASSERT(a_sample_no_led, (adv && s1_valid && !s1_mode) |=> !m_axis_tvalid, "sample made LED")
  `TAD_ASSERT(a_empty_no_led, (adv && !s1_valid) |=> !m_axis_tvalid, "LED from empty stage")
  `TAD_ASSERT_NOW(a_reset_idle, rst |=> (!m_axis_tvalid && !s1_valid), "not idle after reset")

endmodule

// File: tb/tilt_average_led_display_core_tb.sv
// Self-checking testbench for the tilt display core: a directed table, then random phases.
// Needs tad_pkg and tilt_average_led_display_core; LED values come from an in-bench model.
`timescale 1ns / 1ps

module tilt_average_led_display_core_tb;

  localparam int WINDOW         = 128;
  localparam int PWM_TOP        = 16;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int NUM_PHASES     = 10;
  localparam int PHASE_ITEMS    = 150;
  localparam int MAX_PRINTED    = 50;

  // LED pattern per code of bits 8..6, code 0 in the low byte.
  localparam logic [63:0] LED_BY_CODE = {8'd16, 8'd32, 8'd64, 8'd128, 8'd1, 8'd2, 8'd4, 8'd8};

  typedef enum bit {MODE_SAMPLE = 1'b0, MODE_TICK = 1'b1} item_mode_t;

  typedef struct packed {
    item_mode_t  mode;
    logic [15:0] smp;
    logic        fixed;
    logic [7:0]  led;
  } stim_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        cfg_wen       = 1'b0;
  logic        cfg_wdata     = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;   // [15:0] sample
  logic        s_axis_tuser  = 1'b0; // [0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;         // [7:0] led_out

  // Display model state.
  logic signed [15:0]         delay_line [WINDOW];
  logic [$clog2(WINDOW)-1:0]  line_slot   = '0;
  int                         window_total = 0;
  logic [7:0]                 shown_pattern = '0;
  logic [4:0]                 duty_level    = '0;
  logic [4:0]                 pwm_phase     = '0;
  bit                         use_average   = 1'b0;

  logic [7:0] led_expected [$];
  int         error_count  = 0;
  int         burst_left   = 0;
  int         gap_max      = 4;
  int         quiet_cycles = 0;
  logic [31:0] ready_mask  = '1;
  int         ready_pos    = 0;

  stim_row_t directed_rows [20];

  tilt_average_led_display_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Advances the display model by one item; returns 1 when a tick yields an LED value.
  function automatic bit advance_display(input item_mode_t mode, input logic [15:0] smp,
                                         output logic [7:0] led);
    int          value;
    logic [31:0] offs;
    led = '0;
    if (mode == MODE_SAMPLE) begin
      window_total += int'($signed(smp)) - int'(delay_line[line_slot]);
      delay_line[line_slot] = smp;
      line_slot++;
      // Arithmetic shift of the sum rounds toward minus infinity.
      value = use_average ? (window_total >>> tad_pkg::AVG_SHIFT) : int'($signed(smp));
      offs = value - int'(tad_pkg::VALUE_OFFSET);
      shown_pattern = LED_BY_CODE[offs[8:6]*8 +: 8];
      duty_level = offs[5:1];
      return 1'b0;
    end
    led = (pwm_phase < duty_level) ? (shown_pattern >> 1) : shown_pattern;
    pwm_phase = (pwm_phase > PWM_TOP) ? '0 : pwm_phase + 1'b1;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    // Only the first MAX_PRINTED are printed so a broken build does not flood the log.
    if (error_count < MAX_PRINTED)
      $display("ERROR at %0t: %s: got 0x%02h, expected 0x%02h", $time, what, got, want);
    error_count++;
  endtask

  // Sends one item as part of a burst; a new burst may open with a random gap.
  task automatic send_item(input item_mode_t mode, input logic [15:0] smp,
                           input bit fixed, input logic [7:0] fixed_led);
    int         gap;
    logic [7:0] led;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= smp;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (advance_display(mode, smp, led))
      led_expected.push_back(fixed ? fixed_led : led);
  endtask

  // The register is only written once the core has gone quiet.
  task automatic write_use_average(input bit value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (led_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wen <= 1'b0;
    use_average = value;
  endtask

  // Output side stalls on a 32-bit ready mask that is redrawn each round.
  always @(posedge clk) begin
    m_axis_tready <= ready_mask[ready_pos];
    if (ready_pos == 31) begin
      ready_pos = 0;
      if ($urandom_range(0, 3) == 0)
        ready_mask = '1;
      else
        ready_mask = $urandom | (32'd1 << $urandom_range(0, 31));
    end else begin
      ready_pos++;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (led_expected.size() == 0) begin
        report_mismatch("led_out transfer with nothing expected", m_axis_tdata, 'x);
      end else begin
        if (m_axis_tdata !== led_expected[0])
          report_mismatch("led_out", m_axis_tdata, led_expected[0]);
        void'(led_expected.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** tilt_average_led_display_core: FAILED **");
      $finish;
    end
  end

  initial begin
    int          tick_pct;
    int          style;
    int          base;
    int          step;
    item_mode_t  mode;
    logic [15:0] smp;

    foreach (delay_line[i]) delay_line[i] = '0;

    // Raw-sample mode; ticks right after reset show a dark display.
    directed_rows = '{
      '{MODE_TICK,   16'h0000, 1'b1, 8'd0},
      '{MODE_TICK,   16'hFFFF, 1'b1, 8'd0},
      '{MODE_SAMPLE, 16'h0020, 1'b0, 8'd0},
      '{MODE_TICK,   16'h1234, 1'b1, 8'd8},
      '{MODE_SAMPLE, 16'h7FFF, 1'b0, 8'd0},
      '{MODE_TICK,   16'h0000, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'h8000, 1'b0, 8'd0},
      '{MODE_TICK,   16'h8000, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'hFFFF, 1'b0, 8'd0},
      '{MODE_TICK,   16'h7FFF, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'h001F, 1'b0, 8'd0},
      '{MODE_TICK,   16'h0000, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'h0000, 1'b0, 8'd0},
      '{MODE_TICK,   16'h5555, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'h5555, 1'b0, 8'd0},
      '{MODE_TICK,   16'hAAAA, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'hAAAA, 1'b0, 8'd0},
      '{MODE_TICK,   16'h0000, 1'b0, 8'd0},
      '{MODE_SAMPLE, 16'h01E0, 1'b0, 8'd0},
      '{MODE_TICK,   16'h0000, 1'b0, 8'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_use_average(1'b0);

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].smp, directed_rows[i].fixed,
                directed_rows[i].led);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_use_average(ph % 2 == 0);
      gap_max  = (ph % 3 == 0) ? 0 : $urandom_range(1, 8);
      tick_pct = $urandom_range(25, 75);
      style    = $urandom_range(0, 3);
      base     = int'($signed(16'($urandom)));
      step     = $urandom_range(1, 300) * (($urandom_range(0, 1) == 0) ? 1 : -1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        mode = ($urandom_range(0, 99) < tick_pct) ? MODE_TICK : MODE_SAMPLE;
        case (style)
          0: begin
            smp = 16'($urandom);
          end
          1: begin
            // Small noise around one level lets the average settle on a pattern.
            smp = 16'(base + int'($urandom_range(0, 127)) - 64);
          end
          2: begin
            case ($urandom_range(0, 5))
              0:       smp = 16'h7FFF;
              1:       smp = 16'h8000;
              2:       smp = 16'h0000;
              3:       smp = 16'hFFFF;
              4:       smp = 16'h0020;
              default: smp = 16'h001F;
            endcase
          end
          default: begin
            if (mode == MODE_SAMPLE) base += step;
            smp = 16'(base);
          end
        endcase
        if (mode == MODE_TICK && $urandom_range(0, 1) == 0) smp = 16'($urandom);
        send_item(mode, smp, 1'b0, 8'd0);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (led_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("** tilt_average_led_display_core: PASSED **");
    else
      $display("** tilt_average_led_display_core: FAILED **");
    $finish;
  end

endmodule
